// ===== design/assert_macros.svh =====
// assertion macros included by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rstn, prop, msg)
`define ASSERT_NEVER(label, clk, rstn, expr, msg)

`endif

`endif

// ===== design/cabs_pkg.sv =====
// types, constants and codes of the class-aware box suppression block
`default_nettype none

package cabs_pkg;

    // field widths
    localparam int ANCHOR_W = 14;
    localparam int CLASS_W  = 4;
    localparam int CONF_W   = 16;
    localparam int COORD_W  = 16;
    localparam int STATUS_W = 2;
    localparam int KIDX_W   = 9;
    localparam int THR_W    = 16;
    localparam int MAXDET_W = 10;
    localparam int AREA_W   = 2 * COORD_W;

    // stream widths, padded to whole bytes
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 112;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_IOU_THRESHOLD  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DETECTIONS = 1'd1;

    localparam logic [THR_W-1:0]    IOU_THR_RESET = 16'd45875;
    localparam logic [MAXDET_W-1:0] MAX_DET_RESET = 10'd300;

    localparam int MAX_KEPT_DEFAULT = 512;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_KEPT       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SUPPRESSED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED    = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] bottom;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] left;
    } box_t;

    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        box_t               box;
        logic [AREA_W-1:0]  area;
    } kept_entry_t;

endpackage

`default_nettype wire

// ===== design/class_aware_box_suppression.sv =====
// class-aware greedy box suppression with the kept list in one memory
//
//   port group   dir  tdata fields (low bit up)                           tuser   tlast
//   s_           in   anchor, class, confidence, l, t, r, b               -       frame_last
//   m_           out  kept_index, anchor, class, confidence, l, t, r, b   status  frame_end
//   cfg_         in   write enable, register index, data                  -       -
//
// one candidate at a time: the scan reads one kept entry per cycle from the memory
// into a 5-stage overlap pipe; a full list (kept count at or above the cap) skips the scan
// reset (synchronous, active low) empties the kept list; memory contents are not cleared
// the result register holds while m_tready is low; the next request is taken once
// the result is loaded
`default_nettype none

module class_aware_box_suppression #(
    parameter int MAX_KEPT = cabs_pkg::MAX_KEPT_DEFAULT
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    // anchor[13:0] class[17:14] confidence[33:18] left[49:34] top[65:50]
    // right[81:66] bottom[97:82] zero[103:98]
    input  wire  [cabs_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  wire                                 s_tlast,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    // kept_index[8:0] anchor[22:9] class[26:23] confidence[42:27] left[58:43]
    // top[74:59] right[90:75] bottom[106:91] zero[111:107]
    output logic [cabs_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // status[1:0]
    output logic [cabs_pkg::STATUS_W-1:0]       m_tuser,
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    input  wire                                 cfg_we,
    input  wire  [cabs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [cabs_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import cabs_pkg::*;

    `include "assert_macros.svh"

    localparam int CNT_W = $clog2(MAX_KEPT + 1);
    localparam int IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CMP_W = (CNT_W > MAXDET_W) ? CNT_W : MAXDET_W;
    localparam int UNI_W = AREA_W + 1;
    localparam int PRD_W = THR_W + UNI_W;
    localparam int NSTG  = 5;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SPAN = 3'd1;
    localparam logic [2:0] S_AREA = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    // control state
    logic [2:0]          state_reg, state_next;
    logic [THR_W-1:0]    thr_reg;
    logic [MAXDET_W-1:0] maxdet_reg;
    logic [CNT_W-1:0]    kept_count_reg, kept_count_next;
    logic [CNT_W-1:0]    issue_cnt_reg, issue_cnt_next;
    logic [NSTG-1:0]     vld_reg;
    logic                hit_reg, hit_next;
    logic                full_reg, full_next;
    logic                m_valid_reg;

    // candidate
    logic [ANCHOR_W-1:0] cand_anchor_reg;
    logic [CLASS_W-1:0]  cand_class_reg;
    logic [CONF_W-1:0]   cand_conf_reg;
    box_t                cand_box_reg;
    logic                cand_last_reg;
    logic [COORD_W-1:0]  cand_w_reg, cand_h_reg;
    logic [AREA_W-1:0]   cand_area_reg;

    // kept list memory
    kept_entry_t         kept_mem [MAX_KEPT];
    kept_entry_t         rd_data_reg;
    logic                rd_en;
    logic                mem_we;
    kept_entry_t         wr_entry;

    // overlap pipe
    logic [COORD_W-1:0]  il, it, ir, ib;
    logic [COORD_W-1:0]  p1_w_reg, p1_h_reg;
    logic [AREA_W-1:0]   p1_area_reg, p2_area_reg;
    logic                p1_same_reg, p2_same_reg, p3_same_reg, p4_same_reg;
    logic [AREA_W-1:0]   p2_inter_reg, p3_inter_reg, p4_inter_reg;
    logic [UNI_W-1:0]    p3_uni_reg;
    logic [PRD_W-1:0]    p4_prod_reg;
    logic                stage_hit;

    // result
    logic                load_out;
    logic [STATUS_W-1:0] status;
    logic [CMP_W-1:0]    cap;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [STATUS_W-1:0] m_tuser_reg;
    logic                m_tlast_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    assign cap = (CMP_W'(maxdet_reg) < CMP_W'(MAX_KEPT)) ? CMP_W'(maxdet_reg)
                                                         : CMP_W'(MAX_KEPT);

    assign rd_en    = (state_reg == S_SCAN) && (issue_cnt_reg < kept_count_reg);
    assign load_out = (state_reg == S_DONE) && (!m_valid_reg || m_tready);

    assign status = full_reg ? ST_DROPPED : (hit_reg ? ST_SUPPRESSED : ST_KEPT);
    assign mem_we = load_out && (status == ST_KEPT);

    assign wr_entry.cls  = cand_class_reg;
    assign wr_entry.box  = cand_box_reg;
    assign wr_entry.area = cand_area_reg;

    // intersection corners against the kept entry just read
    assign il = (cand_box_reg.left > rd_data_reg.box.left) ? cand_box_reg.left
                                                           : rd_data_reg.box.left;
    assign it = (cand_box_reg.top > rd_data_reg.box.top) ? cand_box_reg.top
                                                         : rd_data_reg.box.top;
    assign ir = (cand_box_reg.right < rd_data_reg.box.right) ? cand_box_reg.right
                                                             : rd_data_reg.box.right;
    assign ib = (cand_box_reg.bottom < rd_data_reg.box.bottom) ? cand_box_reg.bottom
                                                               : rd_data_reg.box.bottom;

    // a zero union implies a zero intersection, so the strict compare already fails
    assign stage_hit = vld_reg[NSTG-1] && p4_same_reg &&
                       ({p4_inter_reg, 16'd0} > p4_prod_reg[PRD_W-1:0]);

    always_comb begin
        state_next      = state_reg;
        kept_count_next = kept_count_reg;
        issue_cnt_next  = issue_cnt_reg;
        hit_next        = hit_reg | stage_hit;
        full_next       = full_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_SPAN;
                end
            end
            S_SPAN: begin
                state_next = S_AREA;
            end
            S_AREA: begin
                full_next      = (CMP_W'(kept_count_reg) >= cap);
                hit_next       = 1'b0;
                issue_cnt_next = '0;
                state_next     = (CMP_W'(kept_count_reg) >= cap) ? S_DONE : S_SCAN;
            end
            S_SCAN: begin
                if (rd_en) begin
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end else if (vld_reg == '0) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (load_out) begin
                    state_next = S_IDLE;
                    if (cand_last_reg) begin
                        kept_count_next = '0;
                    end else if (status == ST_KEPT) begin
                        kept_count_next = kept_count_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            thr_reg        <= IOU_THR_RESET;
            maxdet_reg     <= MAX_DET_RESET;
            kept_count_reg <= '0;
            issue_cnt_reg  <= '0;
            vld_reg        <= '0;
            hit_reg        <= 1'b0;
            full_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            kept_count_reg <= kept_count_next;
            issue_cnt_reg  <= issue_cnt_next;
            vld_reg        <= {vld_reg[NSTG-2:0], rd_en};
            hit_reg        <= hit_next;
            full_reg       <= full_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_IOU_THRESHOLD:  thr_reg    <= cfg_data[THR_W-1:0];
                    REG_MAX_DETECTIONS: maxdet_reg <= cfg_data[MAXDET_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // kept list memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            kept_mem[kept_count_reg[IDX_W-1:0]] <= wr_entry;
        end
        if (rd_en) begin
            rd_data_reg <= kept_mem[issue_cnt_reg[IDX_W-1:0]];
        end
    end

    // candidate capture and area
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_tvalid) begin
            cand_anchor_reg     <= s_tdata[13:0];
            cand_class_reg      <= s_tdata[17:14];
            cand_conf_reg       <= s_tdata[33:18];
            cand_box_reg.left   <= s_tdata[49:34];
            cand_box_reg.top    <= s_tdata[65:50];
            cand_box_reg.right  <= s_tdata[81:66];
            cand_box_reg.bottom <= s_tdata[97:82];
            cand_last_reg       <= s_tlast;
        end
        if (state_reg == S_SPAN) begin
            cand_w_reg <= (cand_box_reg.right > cand_box_reg.left)
                          ? cand_box_reg.right - cand_box_reg.left : '0;
            cand_h_reg <= (cand_box_reg.bottom > cand_box_reg.top)
                          ? cand_box_reg.bottom - cand_box_reg.top : '0;
        end
        if (state_reg == S_AREA) begin
            cand_area_reg <= AREA_W'(cand_w_reg * cand_h_reg);
        end
    end

    // overlap pipe: spans, intersection, union, threshold product
    always_ff @(posedge aclk) begin
        p1_w_reg     <= (ir > il) ? ir - il : '0;
        p1_h_reg     <= (ib > it) ? ib - it : '0;
        p1_area_reg  <= rd_data_reg.area;
        p1_same_reg  <= (rd_data_reg.cls == cand_class_reg);

        p2_inter_reg <= AREA_W'(p1_w_reg * p1_h_reg);
        p2_area_reg  <= p1_area_reg;
        p2_same_reg  <= p1_same_reg;

        p3_uni_reg   <= UNI_W'(UNI_W'(cand_area_reg) + UNI_W'(p2_area_reg)
                               - UNI_W'(p2_inter_reg));
        p3_inter_reg <= p2_inter_reg;
        p3_same_reg  <= p2_same_reg;

        p4_prod_reg  <= PRD_W'(thr_reg * p3_uni_reg);
        p4_inter_reg <= p3_inter_reg;
        p4_same_reg  <= p3_same_reg;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= {5'd0, cand_box_reg.bottom, cand_box_reg.right,
                            cand_box_reg.top, cand_box_reg.left, cand_conf_reg,
                            cand_class_reg, cand_anchor_reg,
                            (status == ST_KEPT) ? KIDX_W'(kept_count_reg) : KIDX_W'(0)};
            m_tuser_reg <= status;
            m_tlast_reg <= cand_last_reg;
        end
    end

    `ASSERT_NEVER(a_count_cap, aclk, aresetn, CMP_W'(kept_count_reg) > CMP_W'(MAX_KEPT), "kept count beyond storage")
    `ASSERT_NEVER(a_issue_bound, aclk, aresetn, (state_reg == S_SCAN) && (issue_cnt_reg > kept_count_reg), "scan read past kept list")
    `ASSERT_CLK(a_idle_pipe, aclk, aresetn, s_tready |-> (vld_reg == '0), "request taken with scan in flight")
    `ASSERT_CLK(a_keep_count, aclk, aresetn, (mem_we && !cand_last_reg) |=> (kept_count_reg == CNT_W'($past(kept_count_reg) + 1'b1)), "kept box did not advance count")

endmodule

`default_nettype wire
